// ===== hw/rtl/wsd_pkg.sv =====
`timescale 1ns / 1ps

package wsd_pkg;

  // width of the payload length counter
  localparam int LEN_BITS = 64;
  localparam logic [LEN_BITS-1:0] LEN_ZERO = '0;
  localparam logic [LEN_BITS-1:0] LEN_ONE  = {{(LEN_BITS-1){1'b0}}, 1'b1};

  // header byte fields
  localparam int FIN_BIT  = 7;
  localparam int MASK_BIT = 7;
  localparam int CTRL_BIT = 3;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam int HDR_IDX_W = 4;
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_FIRST  = 4'd0;
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_SECOND = 4'd1;
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_EXT    = 4'd2;
  localparam logic [HDR_IDX_W-1:0] HDR_END_16     = 4'd4;
  localparam logic [HDR_IDX_W-1:0] HDR_END_64     = 4'd10;

  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_NONE  = 4'h0;

  // command queue between parser and message tracker
  localparam int CQ_AW    = 2;
  localparam int CQ_DEPTH = 1 << CQ_AW;

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_PAYLOAD = 2'd1,
    CMD_MASK    = 2'd2
  } cmd_kind_t;

  // flag: zero length for CMD_BEGIN, frame done for CMD_PAYLOAD
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       fin;
    logic [3:0] opcode;
    logic       flag;
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_END      = 2'd1,
    KIND_CLOSE    = 2'd2,
    KIND_MASK_ERR = 2'd3
  } out_kind_t;

endpackage

// ===== hw/rtl/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps

// Receive-side websocket frame deframer. One stream byte is taken per transfer on the
// in_ queue port and the block sustains one byte per clock while in_full is low: a
// header parser classifies each byte (header fields, 16- or 64-bit big-endian extended
// length, payload) and posts a command to a four-entry command queue; a message tracker
// drains one command per clock, while the output register is free or being taken, into
// that single register. A result passes from the byte through the command queue and
// the result register to the out_ ports. Payload bytes of data frames come out as kind
// 0 carrying the opcode of the first fragment and a last-of-message mark, a final empty
// data frame yields an end marker (kind 1), control frames are swallowed except that a
// complete close frame reports kind 2, and a masked frame reports kind 3 and then halts
// the block: further bytes are accepted and dropped until reset. in_full rises only
// when the command queue backs up behind a stalled result consumer.

module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  // byte input queue
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_rx_byte,
  // result queue
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_payload_byte,
  output logic [3:0] out_message_opcode,
  output logic       out_last_in_message
);

  logic          byte_valid;
  logic          cmd_push;
  wsd_pkg::cmd_t cmd_in;
  logic          cq_full;
  logic          cq_valid;
  logic          cq_pop;
  wsd_pkg::cmd_t cq_head;
  logic          res_valid;
  logic          res_take;

  // input transfer
  assign in_full    = cq_full;
  assign byte_valid = in_push && !cq_full;

  // header parser: one command at most per byte
  wsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .rx_byte    (in_rx_byte),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  // decouples the parser from a stalled result consumer
  wsd_cmd_fifo u_cq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .full     (cq_full),
    .pop      (cq_pop),
    .valid    (cq_valid),
    .head     (cq_head)
  );

  // message tracker and result register
  wsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cq_valid),
    .cmd        (cq_head),
    .cmd_pop    (cq_pop),
    .out_valid  (res_valid),
    .out_take   (res_take),
    .out_kind   (out_kind),
    .out_data   (out_payload_byte),
    .out_opcode (out_message_opcode),
    .out_last   (out_last_in_message)
  );

  // result transfer
  assign out_empty = !res_valid;
  assign res_take  = out_pop && res_valid;

endmodule

// ===== hw/rtl/wsd_front.sv =====
`timescale 1ns / 1ps

module wsd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_valid,
  input  logic [7:0]      rx_byte,
  output logic            cmd_push,
  output wsd_pkg::cmd_t   cmd
);

  logic [wsd_pkg::HDR_IDX_W-1:0] hdr_idx_r, hdr_idx_nxt;
  logic                          fin_r, fin_nxt;
  logic [3:0]                    opc_r, opc_nxt;
  logic                          ext64_r, ext64_nxt;
  logic [wsd_pkg::LEN_BITS-1:0]  rem_r, rem_nxt;
  logic                          in_payload_r, in_payload_nxt;
  logic                          halted_r, halted_nxt;

  logic                          begin_frame;
  logic [wsd_pkg::LEN_BITS-1:0]  frame_len;
  logic [wsd_pkg::HDR_IDX_W-1:0] hdr_end;
  logic [wsd_pkg::HDR_IDX_W-1:0] hdr_idx_inc;
  logic                          done;

  assign hdr_end     = ext64_r ? wsd_pkg::HDR_END_64 : wsd_pkg::HDR_END_16;
  assign hdr_idx_inc = hdr_idx_r + 1'b1;
  assign done        = (rem_r == wsd_pkg::LEN_ONE);

  always_comb begin
    hdr_idx_nxt    = hdr_idx_r;
    fin_nxt        = fin_r;
    opc_nxt        = opc_r;
    ext64_nxt      = ext64_r;
    rem_nxt        = rem_r;
    in_payload_nxt = in_payload_r;
    halted_nxt     = halted_r;
    begin_frame    = 1'b0;
    frame_len      = rem_r;
    cmd_push       = 1'b0;
    cmd            = '0;
    cmd.fin        = fin_r;
    cmd.opcode     = opc_r;
    cmd.data       = rx_byte;

    if (byte_valid && !halted_r) begin
      if (in_payload_r) begin
        rem_nxt  = rem_r - wsd_pkg::LEN_ONE;
        cmd_push = 1'b1;
        cmd.kind = wsd_pkg::CMD_PAYLOAD;
        cmd.flag = done;
        if (done) begin
          in_payload_nxt = 1'b0;
          hdr_idx_nxt    = wsd_pkg::HDR_IDX_FIRST;
        end
      end else if (hdr_idx_r == wsd_pkg::HDR_IDX_FIRST) begin
        fin_nxt     = rx_byte[wsd_pkg::FIN_BIT];
        opc_nxt     = rx_byte[3:0];
        hdr_idx_nxt = wsd_pkg::HDR_IDX_SECOND;
      end else if (hdr_idx_r == wsd_pkg::HDR_IDX_SECOND) begin
        if (rx_byte[wsd_pkg::MASK_BIT]) begin
          halted_nxt  = 1'b1;
          hdr_idx_nxt = wsd_pkg::HDR_IDX_FIRST;
          cmd_push    = 1'b1;
          cmd.kind    = wsd_pkg::CMD_MASK;
        end else if (rx_byte[6:0] < wsd_pkg::LEN_CODE_16) begin
          frame_len   = {{(wsd_pkg::LEN_BITS-7){1'b0}}, rx_byte[6:0]};
          rem_nxt     = frame_len;
          begin_frame = 1'b1;
        end else begin
          rem_nxt     = wsd_pkg::LEN_ZERO;
          ext64_nxt   = (rx_byte[6:0] == wsd_pkg::LEN_CODE_64);
          hdr_idx_nxt = wsd_pkg::HDR_IDX_EXT;
        end
      end else begin
        // big-endian extended length, one byte per transfer
        frame_len   = {rem_r[wsd_pkg::LEN_BITS-9:0], rx_byte};
        rem_nxt     = frame_len;
        hdr_idx_nxt = hdr_idx_inc;
        begin_frame = (hdr_idx_inc == hdr_end);
      end

      if (begin_frame) begin
        hdr_idx_nxt    = wsd_pkg::HDR_IDX_FIRST;
        in_payload_nxt = (frame_len != wsd_pkg::LEN_ZERO);
        cmd_push       = 1'b1;
        cmd.kind       = wsd_pkg::CMD_BEGIN;
        cmd.flag       = (frame_len == wsd_pkg::LEN_ZERO);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_idx_r    <= wsd_pkg::HDR_IDX_FIRST;
      fin_r        <= 1'b0;
      opc_r        <= wsd_pkg::OPC_NONE;
      ext64_r      <= 1'b0;
      rem_r        <= wsd_pkg::LEN_ZERO;
      in_payload_r <= 1'b0;
      halted_r     <= 1'b0;
    end else begin
      hdr_idx_r    <= hdr_idx_nxt;
      fin_r        <= fin_nxt;
      opc_r        <= opc_nxt;
      ext64_r      <= ext64_nxt;
      rem_r        <= rem_nxt;
      in_payload_r <= in_payload_nxt;
      halted_r     <= halted_nxt;
    end
  end

  a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !cmd_push)
    else $error("command issued while halted");

  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> (rem_r != wsd_pkg::LEN_ZERO))
    else $error("payload phase with zero bytes left");

endmodule

// ===== hw/rtl/wsd_cmd_fifo.sv =====
`timescale 1ns / 1ps

module wsd_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wsd_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output wsd_pkg::cmd_t  head
);

  wsd_pkg::cmd_t              mem_r [wsd_pkg::CQ_DEPTH];
  logic [wsd_pkg::CQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [wsd_pkg::CQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [wsd_pkg::CQ_AW:0]    cnt_r, cnt_nxt;
  logic                       do_push, do_pop;

  assign full    = (cnt_r == (wsd_pkg::CQ_AW+1)'(wsd_pkg::CQ_DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (wsd_pkg::CQ_AW+1)'(wsd_pkg::CQ_DEPTH))
    else $error("command queue count overflow");

endmodule

// ===== hw/rtl/wsd_back.sv =====
`timescale 1ns / 1ps

module wsd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  wsd_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_take,
  output logic [1:0]     out_kind,
  output logic [7:0]     out_data,
  output logic [3:0]     out_opcode,
  output logic           out_last
);

  logic [3:0]           first_opc_r, first_opc_nxt;
  logic                 cont_r, cont_nxt;
  logic                 out_valid_r, out_valid_nxt;
  wsd_pkg::out_kind_t   kind_r, kind_nxt;
  logic [7:0]           data_r, data_nxt;
  logic [3:0]           opc_r, opc_nxt;
  logic                 last_r, last_nxt;

  logic                 is_ctrl;
  logic                 emit;
  logic                 can_load;
  logic [3:0]           eff_first;

  assign can_load = !out_valid_r || out_take;
  assign cmd_pop  = cmd_valid && can_load;
  assign is_ctrl  = cmd.opcode[wsd_pkg::CTRL_BIT];
  assign eff_first = (!is_ctrl && !cont_r) ? cmd.opcode : first_opc_r;

  always_comb begin
    first_opc_nxt = first_opc_r;
    cont_nxt      = cont_r;
    emit          = 1'b0;
    kind_nxt      = wsd_pkg::KIND_PAYLOAD;
    data_nxt      = 8'h00;
    opc_nxt       = wsd_pkg::OPC_NONE;
    last_nxt      = 1'b0;

    if (cmd_pop) begin
      unique case (cmd.kind)
        wsd_pkg::CMD_BEGIN: begin
          first_opc_nxt = eff_first;
          if (cmd.flag) begin
            if (is_ctrl) begin
              if (cmd.opcode == wsd_pkg::OPC_CLOSE) begin
                emit     = 1'b1;
                kind_nxt = wsd_pkg::KIND_CLOSE;
                opc_nxt  = wsd_pkg::OPC_CLOSE;
              end
            end else if (cmd.fin) begin
              cont_nxt = 1'b0;
              emit     = 1'b1;
              kind_nxt = wsd_pkg::KIND_END;
              opc_nxt  = eff_first;
              last_nxt = 1'b1;
            end else begin
              cont_nxt = 1'b1;
            end
          end
        end
        wsd_pkg::CMD_PAYLOAD: begin
          if (is_ctrl) begin
            if (cmd.flag && cmd.opcode == wsd_pkg::OPC_CLOSE) begin
              emit     = 1'b1;
              kind_nxt = wsd_pkg::KIND_CLOSE;
              opc_nxt  = wsd_pkg::OPC_CLOSE;
            end
          end else begin
            if (cmd.flag) begin
              cont_nxt = !cmd.fin;
            end
            emit     = 1'b1;
            kind_nxt = wsd_pkg::KIND_PAYLOAD;
            data_nxt = cmd.data;
            opc_nxt  = first_opc_r;
            last_nxt = cmd.flag && cmd.fin;
          end
        end
        wsd_pkg::CMD_MASK: begin
          emit     = 1'b1;
          kind_nxt = wsd_pkg::KIND_MASK_ERR;
        end
        default: begin
        end
      endcase
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_opc_r <= wsd_pkg::OPC_NONE;
      cont_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      first_opc_r <= first_opc_nxt;
      cont_r      <= cont_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= kind_nxt;
      data_r <= data_nxt;
      opc_r  <= opc_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = kind_r;
  assign out_data   = data_r;
  assign out_opcode = opc_r;
  assign out_last   = last_r;

  a_close_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == wsd_pkg::KIND_CLOSE) |->
      (opc_r == wsd_pkg::OPC_CLOSE && !last_r))
    else $error("close result with bad opcode or last mark");

endmodule

// ===== test/tb_websocket_frame_deframer.sv =====
`timescale 1ns / 1ps

// websocket deframer testbench: a directed table first, then random frames in
// several idling phases, then a masked frame that halts the block for good

module tb_websocket_frame_deframer;

  // data and control opcodes used by the stimulus
  localparam logic [3:0] OPC_CONT   = 4'h0;
  localparam logic [3:0] OPC_TEXT   = 4'h1;
  localparam logic [3:0] OPC_BINARY = 4'h2;
  localparam logic [3:0] OPC_PING   = 4'h9;
  localparam logic [3:0] OPC_PONG   = 4'hA;

  localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 20;   // final wait once no result is pending
  localparam int unsigned PHASE_BYTES  = 110;  // random bytes per idling phase

  typedef struct packed {
    wsd_pkg::out_kind_t kind;
    logic [7:0]         data;
    logic [3:0]         opcode;
    logic               last;
  } ws_result_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;     // expected result written out in the row
    ws_result_t result;
  } stim_row_t;

  // header-level cases, one short frame after another
  localparam stim_row_t OPENING_ROWS [22] = '{
    // final text frame, empty: end marker straight after reset
    '{8'h81, 1'b0, '0},
    '{8'h00, 1'b1, '{wsd_pkg::KIND_END, 8'h00, OPC_TEXT, 1'b1}},
    // non-final text frame carrying one zero byte
    '{8'h01, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    // empty close frame in the middle of the message
    '{8'h88, 1'b0, '0},
    '{8'h00, 1'b1, '{wsd_pkg::KIND_CLOSE, 8'h00, wsd_pkg::OPC_CLOSE, 1'b0}},
    // final continuation, 16-bit length of one, byte 0xff closes the message
    '{8'h80, 1'b0, '0},
    '{8'h7E, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    // final binary frame with a 64-bit length of zero
    '{8'h82, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{wsd_pkg::KIND_END, 8'h00, OPC_BINARY, 1'b1}}
  };

  // masked frame: error on the second header byte, then everything is dropped
  localparam stim_row_t CLOSING_ROWS [4] = '{
    '{8'h81, 1'b0, '0},
    '{8'h80, 1'b1, '{wsd_pkg::KIND_MASK_ERR, 8'h00, wsd_pkg::OPC_NONE, 1'b0}},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_payload_byte;
  logic [3:0] out_message_opcode;
  logic       out_last_in_message;

  // typed expectation riding along with the byte currently offered
  logic       typed_ok = 1'b0;
  ws_result_t typed_res = '0;

  // idling knobs, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // hold-off request toggles; the receiver process counts the cycles
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int unsigned hold_left = 0;

  int unsigned bytes_sent = 0;
  int unsigned error_count = 0;
  ws_result_t  pending_results [$];

  // predictor state of the deframer
  logic [3:0]                   hdr_pos = wsd_pkg::HDR_IDX_FIRST;
  logic                         cur_fin = 1'b0;
  logic [3:0]                   cur_opc = wsd_pkg::OPC_NONE;
  logic [3:0]                   msg_opc = wsd_pkg::OPC_NONE;
  logic [6:0]                   len_code = '0;
  logic [wsd_pkg::LEN_BITS-1:0] len_left = wsd_pkg::LEN_ZERO;
  logic                         in_body = 1'b0;
  logic                         frag_open = 1'b0;
  logic                         stopped = 1'b0;

  websocket_frame_deframer DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_rx_byte          (in_rx_byte),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_kind            (out_kind),
    .out_payload_byte    (out_payload_byte),
    .out_message_opcode  (out_message_opcode),
    .out_last_in_message (out_last_in_message)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // header complete: len_left holds the payload length
  task automatic start_frame(output logic got, output ws_result_t r);
    logic ctrl;
    ctrl = cur_opc[wsd_pkg::CTRL_BIT];
    got = 1'b0;
    r = '0;
    hdr_pos = wsd_pkg::HDR_IDX_FIRST;
    // control frames never touch the message in progress
    if (!ctrl && !frag_open)
      msg_opc = cur_opc;
    if (len_left != wsd_pkg::LEN_ZERO) begin
      in_body = 1'b1;
    end else if (ctrl) begin
      if (cur_opc == wsd_pkg::OPC_CLOSE) begin
        got = 1'b1;
        r = '{wsd_pkg::KIND_CLOSE, 8'h00, wsd_pkg::OPC_CLOSE, 1'b0};
      end
    end else if (cur_fin) begin
      frag_open = 1'b0;
      got = 1'b1;
      r = '{wsd_pkg::KIND_END, 8'h00, msg_opc, 1'b1};
    end else begin
      frag_open = 1'b1;
    end
  endtask

  // advance the predictor by one accepted stream byte
  task automatic deframe_byte(input logic [7:0] b, output logic got, output ws_result_t r);
    logic       done;
    logic [3:0] hdr_end;
    got = 1'b0;
    r = '0;
    if (stopped) begin
      // halted after a masked frame: nothing until reset
    end else if (in_body) begin
      len_left = len_left - wsd_pkg::LEN_ONE;
      done = (len_left == wsd_pkg::LEN_ZERO);
      if (done) begin
        in_body = 1'b0;
        hdr_pos = wsd_pkg::HDR_IDX_FIRST;
      end
      if (cur_opc[wsd_pkg::CTRL_BIT]) begin
        // control payload is swallowed; a finished close frame is reported
        if (done && cur_opc == wsd_pkg::OPC_CLOSE) begin
          got = 1'b1;
          r = '{wsd_pkg::KIND_CLOSE, 8'h00, wsd_pkg::OPC_CLOSE, 1'b0};
        end
      end else begin
        if (done)
          frag_open = !cur_fin;
        got = 1'b1;
        r = '{wsd_pkg::KIND_PAYLOAD, b, msg_opc, done && cur_fin};
      end
    end else if (hdr_pos == wsd_pkg::HDR_IDX_FIRST) begin
      cur_fin = b[wsd_pkg::FIN_BIT];
      cur_opc = b[3:0];
      hdr_pos = wsd_pkg::HDR_IDX_SECOND;
    end else if (hdr_pos == wsd_pkg::HDR_IDX_SECOND) begin
      if (b[wsd_pkg::MASK_BIT]) begin
        stopped = 1'b1;
        hdr_pos = wsd_pkg::HDR_IDX_FIRST;
        got = 1'b1;
        r = '{wsd_pkg::KIND_MASK_ERR, 8'h00, wsd_pkg::OPC_NONE, 1'b0};
      end else begin
        len_code = b[6:0];
        if (len_code < wsd_pkg::LEN_CODE_16) begin
          len_left = wsd_pkg::LEN_BITS'(len_code);
          start_frame(got, r);
        end else begin
          len_left = wsd_pkg::LEN_ZERO;
          hdr_pos = wsd_pkg::HDR_IDX_EXT;
        end
      end
    end else begin
      // extended length, big-endian, keeps the low LEN_BITS bits
      hdr_end = (len_code == wsd_pkg::LEN_CODE_16) ? wsd_pkg::HDR_END_16
                                                   : wsd_pkg::HDR_END_64;
      len_left = (len_left << 8) | wsd_pkg::LEN_BITS'(b);
      hdr_pos = hdr_pos + 4'd1;
      if (hdr_pos >= hdr_end)
        start_frame(got, r);
    end
  endtask

  // result check and prediction, both on the edge that completes the transfer
  always @(posedge clk) begin
    ws_result_t want;
    ws_result_t pred;
    logic       got;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d byte %0h opcode %0h last %0b",
                 out_kind, out_payload_byte, out_message_opcode, out_last_in_message);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_kind !== want.kind) begin
            $error("out_kind: expected %0d, actual %0d", want.kind, out_kind);
            error_count++;
          end
          if (out_payload_byte !== want.data) begin
            $error("out_payload_byte: expected %0h, actual %0h", want.data, out_payload_byte);
            error_count++;
          end
          if (out_message_opcode !== want.opcode) begin
            $error("out_message_opcode: expected %0h, actual %0h",
                   want.opcode, out_message_opcode);
            error_count++;
          end
          if (out_last_in_message !== want.last) begin
            $error("out_last_in_message: expected %0b, actual %0b",
                   want.last, out_last_in_message);
            error_count++;
          end
        end
      end
      if (in_push && !in_full) begin
        deframe_byte(in_rx_byte, got, pred);
        // rows with a typed expectation take it instead of the prediction
        if (got)
          pending_results.push_back(typed_ok ? typed_res : pred);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one byte, with random gaps before it, and wait for its transfer
  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input ws_result_t expected = '0);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    typed_ok <= typed;
    typed_res <= expected;
    do
      @(posedge clk);
    while (in_full);
    bytes_sent++;
  endtask

  task automatic send_rows(input stim_row_t rows []);
    foreach (rows[i])
      send_byte(rows[i].rx, rows[i].typed, rows[i].result);
  endtask

  // mostly short frames, some medium, a few that need the 16-bit length
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55)
      return $urandom_range(8);
    else if (r < 90)
      return $urandom_range(125, 9);
    else
      return $urandom_range(300, 126);
  endfunction

  // 0 shortest length form, 1 forced 16-bit, 2 forced 64-bit
  function automatic int unsigned pick_form();
    int unsigned r;
    r = $urandom_range(99);
    return (r < 75) ? 0 : (r < 90) ? 1 : 2;
  endfunction

  // header, extended length as asked, then random payload; never masked
  task automatic send_frame(input logic [7:0] head, input int unsigned len,
                            input int unsigned form);
    logic [63:0] len64;
    len64 = len;
    send_byte(head);
    if (form == 0 && len < 126) begin
      send_byte({1'b0, len64[6:0]});
    end else if (form != 2 && len < 65536) begin
      send_byte({1'b0, wsd_pkg::LEN_CODE_16});
      send_byte(len64[15:8]);
      send_byte(len64[7:0]);
    end else begin
      send_byte({1'b0, wsd_pkg::LEN_CODE_64});
      for (int i = 7; i >= 0; i--)
        send_byte(len64[i*8 +: 8]);
    end
    for (int unsigned k = 0; k < len; k++)
      send_byte(8'($urandom_range(255)));
  endtask

  function automatic logic [2:0] pick_rsv();
    return ($urandom_range(99) < 90) ? 3'b000 : 3'($urandom_range(7));
  endfunction

  // ping, pong, close or any other control opcode, fin bit random
  task automatic send_control();
    logic [3:0] opc;
    int unsigned r;
    r = $urandom_range(99);
    opc = (r < 30) ? OPC_PING : (r < 50) ? OPC_PONG : (r < 85) ? wsd_pkg::OPC_CLOSE
        : 4'($urandom_range(15, 8));
    send_frame({1'($urandom_range(1)), pick_rsv(), opc},
               ($urandom_range(99) < 70) ? $urandom_range(12) : $urandom_range(125),
               pick_form());
  endtask

  // one message: mostly well-formed fragments, sometimes odd opcodes,
  // control frames slipped in between fragments
  task automatic send_message();
    int unsigned nfrag;
    logic [3:0]  opc;
    nfrag = ($urandom_range(99) < 60) ? 1 : $urandom_range(4, 2);
    for (int unsigned k = 0; k < nfrag; k++) begin
      if ($urandom_range(99) < 20)
        send_control();
      if (k == 0)
        opc = ($urandom_range(99) < 85) ? ($urandom_range(1) ? OPC_TEXT : OPC_BINARY)
            : 4'($urandom_range(7));
      else
        opc = ($urandom_range(99) < 85) ? OPC_CONT : 4'($urandom_range(7));
      send_frame({k == nfrag - 1, pick_rsv(), opc}, pick_len(), pick_form());
    end
  endtask

  initial begin
    int unsigned target;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_rows(OPENING_ROWS);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      if (phase == 0) begin
        // receiver holds off while a long frame streams in: the block backs up
        hold_req <= ~hold_req;
        send_frame({1'b1, 3'b000, OPC_BINARY}, 150, 0);
      end
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        // a share of frames with a fully random first header byte
        if ($urandom_range(99) < 12)
          send_frame(8'($urandom_range(255)), pick_len(), pick_form());
        else
          send_message();
      end
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_rows(CLOSING_ROWS);
    in_push <= 1'b0;

    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
